>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the frame engine.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> sv/rtumfe_pkg.sv
// Shared types, codes and CRC helpers for the RTU master frame engine.
// No dependencies.
`default_nettype none

package rtumfe_pkg;

	// default receive buffer size in bytes
	localparam int RX_BUFFER_BYTES_DEF = 256;

	// port widths
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 16;
	localparam int CMP_W     = 10;   // holds any position or count + 5
	localparam int RES_MAX   = 8;
	localparam int RES_CNT_W = 4;

	// CRC-16, reflected polynomial
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// input operations
	localparam logic [1:0] OP_ISSUE  = 2'd0;
	localparam logic [1:0] OP_RXBYTE = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;

	// request kinds
	localparam logic [2:0] KIND_COILS     = 3'd0;
	localparam logic [2:0] KIND_DISCRETE  = 3'd1;
	localparam logic [2:0] KIND_HOLDING   = 3'd2;
	localparam logic [2:0] KIND_INPUT     = 3'd3;
	localparam logic [2:0] KIND_WR_COIL   = 3'd4;
	localparam logic [2:0] KIND_WR_REG    = 3'd5;

	// function codes
	localparam logic [7:0] FN_NONE       = 8'h00;
	localparam logic [7:0] FN_RD_COILS   = 8'h01;
	localparam logic [7:0] FN_RD_DISC    = 8'h02;
	localparam logic [7:0] FN_RD_HOLDING = 8'h03;
	localparam logic [7:0] FN_RD_INPUT   = 8'h04;
	localparam logic [7:0] FN_WR_COIL    = 8'h05;
	localparam logic [7:0] FN_WR_REG     = 8'h06;

	// result kinds
	localparam logic [1:0] OUT_REQ    = 2'd0;
	localparam logic [1:0] OUT_DATA   = 2'd1;
	localparam logic [1:0] OUT_STATUS = 2'd2;

	// frame status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_REPLY = 3'd1;
	localparam logic [2:0] ST_SLAVE    = 3'd2;
	localparam logic [2:0] ST_FUNCTION = 3'd3;
	localparam logic [2:0] ST_CRC      = 3'd4;
	localparam logic [2:0] ST_ECHO     = 3'd5;
	localparam logic [2:0] ST_LENGTH   = 3'd6;

	// one registered input item, with the CRC over the first three request bytes
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  slave;
		logic [2:0]  kind;
		logic [15:0] start;
		logic [15:0] qv;
		logic [7:0]  rx;
		logic [15:0] crc_part;
	} item_t;

	// one result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [2:0] status;
		logic       last;
	} res_t;

	// one byte through the reflected CRC-16
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		end
		return x;
	endfunction

	// function code for a request kind
	function automatic logic [7:0] fn_code(input logic [2:0] kind);
		logic [7:0] f;
		unique case (kind)
			KIND_COILS:    f = FN_RD_COILS;
			KIND_DISCRETE: f = FN_RD_DISC;
			KIND_HOLDING:  f = FN_RD_HOLDING;
			KIND_INPUT:    f = FN_RD_INPUT;
			KIND_WR_COIL:  f = FN_WR_COIL;
			KIND_WR_REG:   f = FN_WR_REG;
			default:       f = FN_NONE;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

>>> sv/rtumfe_proc.sv
// Frame state and per-item result logic of the RTU master frame engine.
// Depends on rtumfe_pkg.
`default_nettype none

module rtumfe_proc
	import rtumfe_pkg::*;
#(
	parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire item_t                item,
	output res_t [RES_MAX-1:0]        res,
	output logic [RES_CNT_W-1:0]      res_cnt
);

	localparam int POS_W = $clog2(RX_BUFFER_BYTES);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(RX_BUFFER_BYTES - 1);

	// reception state
	logic [15:0]      crc_q, crc_n;
	logic [POS_W-1:0] pos_q, pos_n;
	logic [7:0]       cnt_q, cnt_n;
	logic [7:0]       exp_slave_q, exp_slave_n;
	logic [7:0]       exp_fn_q, exp_fn_n;
	logic [7:0]       held_q, held_n;
	logic [2:0]       err_q, err_n;
	logic [7:0]       copy_q [RES_MAX];
	logic             copy_we;

	// request bytes
	logic [7:0]  rb [RES_MAX];
	logic [15:0] crc_full;
	logic [15:0] crc_rx;
	logic [CMP_W-1:0] pe, ce;
	logic [2:0]  status;

	// request frame assembly
	always_comb begin
		crc_full = crc_byte(crc_byte(crc_byte(item.crc_part, item.start[7:0]),
			item.qv[15:8]), item.qv[7:0]);
		rb[0] = item.slave;
		rb[1] = fn_code(item.kind);
		rb[2] = item.start[15:8];
		rb[3] = item.start[7:0];
		rb[4] = item.qv[15:8];
		rb[5] = item.qv[7:0];
		rb[6] = crc_full[7:0];
		rb[7] = crc_full[15:8];
	end

	assign crc_rx = crc_byte(crc_q, item.rx);
	assign pe     = CMP_W'(pos_q);
	assign ce     = CMP_W'(cnt_q);

	// end-of-frame status
	always_comb begin
		if (pos_q == '0) begin
			status = ST_NO_REPLY;
		end else if (exp_fn_q == FN_NONE) begin
			status = ST_FUNCTION;
		end else if (err_q != ST_OK) begin
			status = err_q;
		end else if (exp_fn_q >= FN_WR_COIL) begin
			status = (pe < CMP_W'(8)) ? ST_LENGTH : ST_OK;
		end else begin
			status = (pe < ce + CMP_W'(5)) ? ST_LENGTH : ST_OK;
		end
	end

	// next state and results
	always_comb begin
		crc_n       = crc_q;
		pos_n       = pos_q;
		cnt_n       = cnt_q;
		exp_slave_n = exp_slave_q;
		exp_fn_n    = exp_fn_q;
		held_n      = held_q;
		err_n       = err_q;
		copy_we     = 1'b0;
		res         = '0;
		res_cnt     = '0;
		unique case (item.op)
			OP_ISSUE: begin
				if (item.kind <= KIND_WR_REG) begin
					copy_we     = 1'b1;
					exp_slave_n = rb[0];
					exp_fn_n    = rb[1];
					crc_n       = CRC_INIT;
					pos_n       = '0;
					cnt_n       = '0;
					held_n      = '0;
					err_n       = ST_OK;
					for (int i = 0; i < RES_MAX; i++) begin
						res[i] = '{kind: OUT_REQ, value: rb[i], status: ST_OK,
							last: (i == RES_MAX - 1)};
					end
					res_cnt = RES_CNT_W'(RES_MAX);
				end
			end
			OP_RXBYTE: begin
				if (pos_q < POS_LIMIT) begin
					pos_n = pos_q + POS_W'(1);
					if (exp_fn_q == FN_NONE) begin
						// no request pending: count only
					end else if (exp_fn_q >= FN_WR_COIL) begin
						// write reply must echo the request
						if (pe < CMP_W'(8) && item.rx != copy_q[pos_q[2:0]] && err_q == ST_OK) begin
							err_n = ST_ECHO;
						end
					end else begin
						priority if (pe == CMP_W'(0)) begin
							crc_n = crc_rx;
							if (item.rx != exp_slave_q && err_q == ST_OK) begin
								err_n = ST_SLAVE;
							end
						end else if (pe == CMP_W'(1)) begin
							crc_n = crc_rx;
							if (item.rx != exp_fn_q && err_q == ST_OK) begin
								err_n = ST_FUNCTION;
							end
						end else if (pe == CMP_W'(2)) begin
							crc_n = crc_rx;
							cnt_n = item.rx;
						end else if (pe < ce + CMP_W'(3)) begin
							crc_n = crc_rx;
							if (err_q == ST_OK) begin
								if (exp_fn_q == FN_RD_HOLDING) begin
									// data index even when position is odd
									if (pos_q[0]) begin
										if (pe == ce + CMP_W'(2)) begin
											res[0]  = '{kind: OUT_DATA, value: item.rx,
												status: ST_OK, last: 1'b0};
											res_cnt = RES_CNT_W'(1);
										end else begin
											held_n = item.rx;
										end
									end else begin
										res[0]  = '{kind: OUT_DATA, value: item.rx,
											status: ST_OK, last: 1'b0};
										res[1]  = '{kind: OUT_DATA, value: held_q,
											status: ST_OK, last: 1'b0};
										res_cnt = RES_CNT_W'(2);
									end
								end else begin
									res[0]  = '{kind: OUT_DATA, value: item.rx,
										status: ST_OK, last: 1'b0};
									res_cnt = RES_CNT_W'(1);
								end
							end
						end else if (pe == ce + CMP_W'(3)) begin
							if (item.rx != crc_q[7:0] && err_q == ST_OK) begin
								err_n = ST_CRC;
							end
						end else if (pe == ce + CMP_W'(4)) begin
							if (item.rx != crc_q[15:8] && err_q == ST_OK) begin
								err_n = ST_CRC;
							end
						end else begin
							// bytes after the CRC are ignored
						end
					end
				end
			end
			OP_END: begin
				res[0]  = '{kind: OUT_STATUS, value: 8'h00, status: status, last: 1'b0};
				res_cnt = RES_CNT_W'(1);
				crc_n   = CRC_INIT;
				pos_n   = '0;
				cnt_n   = '0;
				held_n  = '0;
				err_n   = ST_OK;
			end
			default: begin
				// unused operation code: no effect
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_INIT;
			pos_q       <= '0;
			cnt_q       <= '0;
			exp_slave_q <= '0;
			exp_fn_q    <= FN_NONE;
			held_q      <= '0;
			err_q       <= ST_OK;
		end else if (fire) begin
			crc_q       <= crc_n;
			pos_q       <= pos_n;
			cnt_q       <= cnt_n;
			exp_slave_q <= exp_slave_n;
			exp_fn_q    <= exp_fn_n;
			held_q      <= held_n;
			err_q       <= err_n;
		end
	end

	// remembered request frame
	always_ff @(posedge clk) begin
		if (fire && copy_we) begin
			for (int i = 0; i < RES_MAX; i++) begin
				copy_q[i] <= rb[i];
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/rtu_master_frame_engine_top.sv
// RTU master frame engine: Modbus RTU request builder and reply checker.
// An issue item (tuser 0) yields eight request bytes with CRC-16, low byte first,
// the eighth marked by tlast. Received-byte items (tuser 1) are checked against
// the pending request; read data is passed on, holding-register bytes swapped in
// pairs. An end-of-frame item (tuser 2) yields one status item. Items pass an input
// register and then the frame logic into an eight-entry result register. An item
// enters every cycle as long as the result register drains: received bytes run at
// one per cycle, while a request or a holding-register pair holds the input until
// all its result items are taken. Depends on rtumfe_pkg and rtumfe_proc.
`default_nettype none

module rtu_master_frame_engine_top
	import rtumfe_pkg::*;
#(
	parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input items
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// [7:0] slave_address, [10:8] request_kind, [26:11] start_number,
	// [42:27] quantity_or_value, [50:43] rx_byte, [55:51] zero
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// [1:0] operation
	input  wire logic [1:0]           s_tuser,
	// result items
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [7:0] byte_value, [10:8] frame_status, [15:11] zero
	output logic [M_TDATA_W-1:0]      m_tdata,
	// [1:0] out_kind
	output logic [1:0]                m_tuser,
	output logic                      m_tlast
);

	// input unpack
	logic [7:0]  in_slave;
	logic [2:0]  in_kind;
	logic [15:0] in_start;
	logic [15:0] in_qv;
	logic [15:0] qv_map;
	item_t       item_in;

	assign in_slave = s_tdata[7:0];
	assign in_kind  = s_tdata[10:8];
	assign in_start = s_tdata[26:11];
	assign in_qv    = s_tdata[42:27];

	// write-coil value is on/off only
	assign qv_map = (in_kind == KIND_WR_COIL) ? ((in_qv != 16'h0000) ? 16'hFF00 : 16'h0000)
		: in_qv;

	always_comb begin
		item_in.op       = s_tuser;
		item_in.slave    = in_slave;
		item_in.kind     = in_kind;
		item_in.start    = in_start;
		item_in.qv       = qv_map;
		item_in.rx       = s_tdata[50:43];
		item_in.crc_part = crc_byte(crc_byte(crc_byte(CRC_INIT, in_slave), fn_code(in_kind)),
			in_start[15:8]);
	end

	// input register
	logic  v_s1;
	item_t item_s1;
	logic  accept;
	logic  adv;

	// result register
	res_t [RES_MAX-1:0]     ob_q;
	logic [RES_CNT_W-1:0]   ob_cnt_q;
	logic [RES_CNT_W-1:0]   cnt_after;
	logic                   take;
	res_t [RES_MAX-1:0]     res;
	logic [RES_CNT_W-1:0]   res_cnt;

	assign take      = m_tvalid & m_tready;
	assign cnt_after = ob_cnt_q - RES_CNT_W'(take);
	assign adv       = v_s1 && (cnt_after == '0);
	assign s_tready  = !v_s1 || adv;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	// frame logic
	rtumfe_proc #(
		.RX_BUFFER_BYTES(RX_BUFFER_BYTES)
	) u_proc (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.item    (item_s1),
		.res     (res),
		.res_cnt (res_cnt)
	);

	// result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= '0;
		end else if (adv) begin
			ob_cnt_q <= res_cnt;
		end else if (take) begin
			ob_cnt_q <= cnt_after;
		end
	end

	// result entries: load a bundle or shift down one on each take
	always_ff @(posedge clk) begin
		if (adv) begin
			ob_q <= res;
		end else if (take) begin
			for (int i = 0; i < RES_MAX - 1; i++) begin
				ob_q[i] <= ob_q[i+1];
			end
		end
	end

	// output pack
	assign m_tvalid = (ob_cnt_q != '0);
	assign m_tdata  = {5'b0, ob_q[0].status, ob_q[0].value};
	assign m_tuser  = ob_q[0].kind;
	assign m_tlast  = ob_q[0].last;

endmodule

`default_nettype wire

>>> sv/rtumfe_checker.sv
// Port-level checks for the RTU master frame engine, bound to the top level.
// Depends on rtumfe_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rtumfe_checker
	import rtumfe_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [1:0]           m_tuser,
	input wire logic                 m_tlast
);

	// valid status item and valid byte item on the result side
	logic out_status;
	logic out_byte;

	assign out_status = m_tvalid && (m_tuser == OUT_STATUS);
	assign out_byte   = m_tvalid && (m_tuser != OUT_STATUS);

	// a stalled result item holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// only request bytes close a run
	`ASSERT_IMPL(a_last_req, clk, arst_n, m_tvalid && m_tlast, m_tuser == OUT_REQ)

	// status items carry no byte and no last mark
	`ASSERT_IMPL(a_status_clean, clk, arst_n, out_status, m_tdata[7:0] == 8'h00 && !m_tlast)

	// byte items carry a zero status
	`ASSERT_IMPL(a_byte_status, clk, arst_n, out_byte, m_tdata[10:8] == ST_OK)

endmodule

bind rtu_master_frame_engine_top rtumfe_checker u_rtumfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
